[src/pls_pkg.sv]
package pls_pkg;

    // Word width of one list element
    localparam int unsigned DATA_W = 32;

    // Readout never returns more than this many elements
    localparam int unsigned MAX_READOUT = 64;

    // Operation codes carried in mode
    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_INS_BACK  = 3'd1;
    localparam logic [2:0] MODE_INS_POS   = 3'd2;
    localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
    localparam logic [2:0] MODE_DEL_POS   = 3'd5;
    localparam logic [2:0] MODE_READOUT   = 3'd6;
    localparam logic [2:0] MODE_COUNT     = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ELEMENT = 2'd3;

endpackage

[src/pls_ram.sv]
module pls_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/positional_list_store.sv]
// positional_list_store: ordered list of up to CAPACITY signed 32-bit words.
// Input channel (in_valid/in_stall) takes one command word: mode, item_in and
// position. Output channel (out_valid/out_stall) returns result words; the last
// word caused by a command carries last_flag.
// Elements live in a single-port-write, registered-read RAM. A small sequencer
// moves elements one at a time through that RAM (read, then write one slot
// over). Inserts shift the elements at and above the position up, top first;
// deletes shift those above it down. Insert at back writes directly; delete
// at back, count and errors go straight to the summary word. Readout returns
// at most 64 elements, one word each; an empty list gives one summary word.
// in_stall is high from acceptance until the last result is loaded into the
// output register; a new command is taken while that result still waits.
// When the receiver stalls, the output word holds and the sequencer waits.
// Reset empties the list at once (count goes to zero); RAM contents are not
// cleared, and only positions below the count are ever read.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [31:0] item_in,
    input  logic [6:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] item_out,
    output logic [6:0]         element_index,
    output logic [6:0]         element_count,
    output logic [1:0]         status,
    output logic               last_flag
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_DEL,
        S_DEL_WR,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            cur_reg, cur_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] item_reg, item_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [1:0]               op_status_reg, op_status_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_item_reg, out_item_next;
    logic [6:0]               out_index_reg, out_index_next;
    logic [6:0]               out_count_reg, out_count_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic                     out_last_reg, out_last_next;

    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [DATA_W-1:0]        ram_wr_data;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;

    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            cnt_x;
    logic [XW-1:0]            cur_x;
    logic                     list_full;
    logic                     list_empty;
    logic                     out_free;
    logic                     rd_last;

    pls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared compare operands
    assign pos_x      = XW'(position);
    assign cnt_x      = XW'(count_reg);
    assign cur_x      = XW'(cur_reg);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign out_free   = !out_valid_reg || !out_stall;
    assign rd_last    = (cur_x + XW'(1) == cnt_x) || (cur_x == XW'(MAX_READOUT - 1));

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        op_status_next  = op_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_item_next   = out_item_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cur_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next      = item_in;
                    op_status_next = ST_DONE;
                    state_next     = S_DONE;
                    case (mode)
                        MODE_INS_FRONT, MODE_INS_BACK:
                        begin
                            if (list_full)
                            begin
                                op_status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = (mode == MODE_INS_FRONT) ? '0 : AW'(count_reg);
                                cur_next   = AW'(count_reg);
                                state_next = S_INS;
                            end
                        end
                        MODE_INS_POS:
                        begin
                            if (pos_x == '0 || pos_x > cnt_x + XW'(1))
                            begin
                                op_status_next = ST_IGNORED;
                            end
                            else if (list_full)
                            begin
                                op_status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = AW'(pos_x - XW'(1));
                                cur_next   = AW'(count_reg);
                                state_next = S_INS;
                            end
                        end
                        MODE_DEL_FRONT:
                        begin
                            if (list_empty)
                            begin
                                op_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                cur_next   = '0;
                                state_next = S_DEL;
                            end
                        end
                        MODE_DEL_BACK:
                        begin
                            // Last slot is simply dropped, storage untouched
                            if (list_empty)
                            begin
                                op_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        MODE_DEL_POS:
                        begin
                            if (pos_x == '0 || pos_x > cnt_x)
                            begin
                                op_status_next = ST_IGNORED;
                            end
                            else
                            begin
                                cur_next   = AW'(pos_x - XW'(1));
                                state_next = S_DEL;
                            end
                        end
                        MODE_READOUT:
                        begin
                            if (!list_empty)
                            begin
                                cur_next   = '0;
                                state_next = S_RD_ISSUE;
                            end
                        end
                        MODE_COUNT:
                        begin
                            op_status_next = ST_DONE;
                        end
                        default:
                        begin
                            op_status_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Open a hole at pos by moving elements up, top first
            S_INS:
            begin
                if (cur_reg == pos_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pos_reg;
                    ram_wr_data = $unsigned(item_reg);
                    count_next  = count_reg + CW'(1);
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_reg - AW'(1);
                    state_next  = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg;
                cur_next    = cur_reg - AW'(1);
                state_next  = S_INS;
            end

            // Close the gap at cur by moving elements down
            S_DEL:
            begin
                if (XW'(cur_reg) + XW'(1) == cnt_x)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cur_reg + AW'(1);
                    state_next  = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg;
                cur_next    = cur_reg + AW'(1);
                state_next  = S_DEL;
            end

            S_RD_ISSUE:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_RD_DATA;
            end

            // One element word per read; waits while the output is full
            S_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = $signed(ram_rd_data);
                    out_index_next  = 7'(cur_x + XW'(1));
                    out_count_next  = 7'(count_reg);
                    out_status_next = ST_ELEMENT;
                    out_last_next   = rd_last;
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = cur_reg + AW'(1);
                        state_next = S_RD_ISSUE;
                    end
                end
            end

            // Single summary word
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_item_next   = '0;
                    out_index_next  = '0;
                    out_count_next  = 7'(count_reg);
                    out_status_next = op_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            pos_reg        <= '0;
            item_reg       <= '0;
            count_reg      <= '0;
            op_status_reg  <= ST_DONE;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
            out_index_reg  <= '0;
            out_count_reg  <= '0;
            out_status_reg <= ST_DONE;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            pos_reg        <= pos_next;
            item_reg       <= item_next;
            count_reg      <= count_next;
            op_status_reg  <= op_status_next;
            out_valid_reg  <= out_valid_next;
            out_item_reg   <= out_item_next;
            out_index_reg  <= out_index_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign item_out      = out_item_reg;
    assign element_index = out_index_reg;
    assign element_count = out_count_reg;
    assign status        = out_status_reg;
    assign last_flag     = out_last_reg;

    // Count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= XW'(CAPACITY))
        else $error("element count above capacity");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("element count jumped");

    // RAM writes stay inside the occupied region plus one slot
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (XW'(ram_wr_addr) <= cnt_x && XW'(ram_wr_addr) < XW'(CAPACITY)))
        else $error("RAM write outside list");

    // A count request goes straight to the summary word
    a_count_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_COUNT) |=> (state_reg == S_DONE))
        else $error("count request not answered at once");

endmodule

[tb/tb_top.sv]
module tb_top;
    import pls_pkg::*;

    localparam int LIST_CAP    = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 300;
    localparam int LONG_HOLD   = 400;

    // One result word as the block returns it
    typedef struct packed {
        logic signed [31:0] item;
        logic [6:0]         index;
        logic [6:0]         count;
        logic [1:0]         status;
        logic               last;
    } result_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         mode = MODE_COUNT;
    logic signed [31:0] item_in = '0;
    logic [6:0]         position = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] item_out;
    logic [6:0]         element_index;
    logic [6:0]         element_count;
    logic [1:0]         status;
    logic               last_flag;

    // Shadow copy of the list contents and its length
    logic signed [31:0] shadow_words [LIST_CAP];
    int                 shadow_count = 0;

    // Result words still owed by the block, oldest first
    result_word_t       awaited_words [$];

    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    bit                 quiet = 1'b0;
    int                 hold_request_len = 0;
    int                 hold_left = 0;
    int                 stall_left = 0;
    int                 run_left = 0;

    logic [2:0] insert_ops [3] = '{MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS};
    logic [2:0] delete_ops [3] = '{MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS};

    positional_list_store #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .item_in      (item_in),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_out     (item_out),
        .element_index(element_index),
        .element_count(element_count),
        .status       (status),
        .last_flag    (last_flag)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("positional_list_store test failed");
            $finish;
        end
    end

    // Apply one command to the shadow list and queue the words it returns
    function automatic void apply_list_op(logic [2:0] op, logic signed [31:0] word,
                                          logic [6:0] pos);
        int           p;
        int           n;
        int           i;
        int           lim;
        logic [1:0]   st;
        result_word_t r;
        p  = int'(pos);
        n  = shadow_count;
        st = ST_DONE;
        case (op)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS:
            begin
                if (op == MODE_INS_FRONT)
                    p = 1;
                else if (op == MODE_INS_BACK)
                    p = n + 1;
                // position check comes ahead of the full check
                if (p < 1 || p > n + 1)
                    st = ST_IGNORED;
                else if (n >= LIST_CAP)
                    st = ST_FULL;
                else
                begin
                    for (i = n; i >= p; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p - 1] = word;
                    shadow_count = n + 1;
                end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS:
            begin
                if (op == MODE_DEL_FRONT)
                    p = 1;
                else if (op == MODE_DEL_BACK)
                    p = n;
                // empty list falls out here too
                if (p < 1 || p > n)
                    st = ST_IGNORED;
                else
                begin
                    for (i = p; i < n; i++)
                        shadow_words[i - 1] = shadow_words[i];
                    shadow_count = n - 1;
                end
            end
            MODE_READOUT:
            begin
                if (n > 0)
                begin
                    lim = (n < MAX_READOUT) ? n : MAX_READOUT;
                    for (i = 0; i < lim; i++)
                    begin
                        r.item   = shadow_words[i];
                        r.index  = 7'(i + 1);
                        r.count  = 7'(n);
                        r.status = ST_ELEMENT;
                        r.last   = (i + 1 == lim);
                        awaited_words.push_back(r);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        r.item   = '0;
        r.index  = '0;
        r.count  = 7'(shadow_count);
        r.status = st;
        r.last   = 1'b1;
        awaited_words.push_back(r);
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in range, sometimes anything the field can hold
    function automatic logic [6:0] pick_position(int upper);
        if (upper >= 1 && $urandom_range(0, 4) != 0)
            return 7'($urandom_range(1, upper));
        return 7'($urandom_range(0, 127));
    endfunction

    // Offer one command word and hold it until taken
    task automatic send_word(logic [2:0] op, logic signed [31:0] word, logic [6:0] pos);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        item_in  <= word;
        position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_list_op(op, word, pos);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_op();
        int         pick;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = insert_ops[pick % 3];
        else if (pick < 84)
            op = delete_ops[pick % 3];
        else if (pick < 92)
            op = MODE_READOUT;
        else
            op = MODE_COUNT;
        if (op == MODE_INS_POS)
            send_word(op, rand_word(), pick_position(shadow_count + 1));
        else
            send_word(op, rand_word(), pick_position(shadow_count));
    endtask

    // Readout, count, every delete and out-of-range positional inserts against an empty list
    task automatic test_empty_list();
        send_word(MODE_READOUT, rand_word(), 7'd0);
        send_word(MODE_COUNT, rand_word(), 7'd127);
        send_word(MODE_DEL_FRONT, rand_word(), 7'd1);
        send_word(MODE_DEL_BACK, rand_word(), 7'd1);
        send_word(MODE_DEL_POS, rand_word(), 7'd1);
        send_word(MODE_DEL_POS, rand_word(), 7'd0);
        send_word(MODE_INS_POS, rand_word(), 7'd0);
        send_word(MODE_INS_POS, rand_word(), 7'd2);
        send_word(MODE_INS_POS, rand_word(), 7'd127);
    endtask

    // Extremes of the data, inserts and deletes at the ends and in the middle
    task automatic test_basic_ops();
        send_word(MODE_INS_POS, 32'sh7FFF_FFFF, 7'd1);
        send_word(MODE_INS_FRONT, 32'sh8000_0000, 7'd0);
        send_word(MODE_INS_BACK, 32'sh0000_0000, 7'd127);
        send_word(MODE_INS_POS, -32'sd1, 7'd4);
        send_word(MODE_INS_POS, 32'sh5A5A_5A5A, 7'd2);
        send_word(MODE_INS_POS, 32'sh0F0F_0F0F, 7'd7);
        send_word(MODE_READOUT, rand_word(), 7'd0);
        send_word(MODE_DEL_POS, rand_word(), 7'd5);
        send_word(MODE_DEL_POS, rand_word(), 7'd5);
        send_word(MODE_DEL_POS, rand_word(), 7'd2);
        send_word(MODE_DEL_BACK, rand_word(), 7'd0);
        send_word(MODE_DEL_FRONT, rand_word(), 7'd0);
        send_word(MODE_COUNT, rand_word(), 7'd0);
        send_word(MODE_READOUT, rand_word(), 7'd0);
        send_word(MODE_DEL_POS, rand_word(), 7'd127);
    endtask

    // Fill to capacity, hit the full cases, read all of it, then drain part way
    task automatic test_fill_to_capacity();
        while (shadow_count < LIST_CAP)
            send_word(insert_ops[$urandom_range(0, 2)], rand_word(),
                      7'($urandom_range(1, shadow_count + 1)));
        send_word(MODE_INS_FRONT, rand_word(), 7'd0);
        send_word(MODE_INS_BACK, rand_word(), 7'd0);
        send_word(MODE_INS_POS, rand_word(), 7'd65);
        send_word(MODE_INS_POS, rand_word(), 7'd1);
        send_word(MODE_INS_POS, rand_word(), 7'd66);
        send_word(MODE_INS_POS, rand_word(), 7'd0);
        send_word(MODE_COUNT, rand_word(), 7'd0);
        send_word(MODE_READOUT, rand_word(), 7'd0);
        send_word(MODE_DEL_POS, rand_word(), 7'd64);
        send_word(MODE_DEL_POS, rand_word(), 7'd64);
        repeat (28)
            send_word(delete_ops[$urandom_range(0, 2)], rand_word(),
                      7'($urandom_range(1, shadow_count)));
    endtask

    // Receiver holds off for a long time while commands keep coming
    task automatic test_receiver_hold();
        wait_drained();
        hold_request_len = LONG_HOLD;
        repeat (5) send_random_op();
        send_word(MODE_READOUT, rand_word(), 7'd0);
        repeat (6) send_random_op();
        // sender stays quiet until everything is back
        wait_drained();
    endtask

    task automatic test_random_ops(int n);
        repeat (n) send_random_op();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_quiet_tail(int n);
        quiet = 1'b1;
        repeat (n) send_random_op();
    endtask

    // Result checking and receiver stall pattern
    always @(posedge clk)
    begin : receiver
        result_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: item_out=%0d index=%0d count=%0d status=%0d last=%0d",
                             item_out, element_index, element_count, status, last_flag);
            end
            else
            begin
                want = awaited_words.pop_front();
                if (item_out !== want.item || element_index !== want.index ||
                    element_count !== want.count || status !== want.status ||
                    last_flag !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("word mismatch: expected item_out=%0d index=%0d count=%0d status=%0d last=%0d",
                                 $signed(want.item), want.index, want.count, want.status, want.last);
                        $display("                    got item_out=%0d index=%0d count=%0d status=%0d last=%0d",
                                 item_out, element_index, element_count, status, last_flag);
                    end
                end
            end
        end

        if (hold_request_len > 0)
        begin
            hold_left = hold_request_len;
            hold_request_len = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (run_left > 0)
        begin
            run_left--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            run_left = $urandom_range(1, 24) - 1;
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_fill_to_capacity();
        test_receiver_hold();
        test_random_ops(70);
        test_quiet_tail(20);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_words.size() == 0)
            $display("positional_list_store test passed");
        else
            $display("positional_list_store test failed");
        $finish;
    end

endmodule

[sim.f]
src/pls_pkg.sv
src/pls_ram.sv
src/positional_list_store.sv
tb/tb_top.sv
